// ===== src/bpk_pkg.sv =====
// Shared constants, codes and transaction types of the button-light MIDI packet packer.
`default_nettype none
package bpk_pkg;

   localparam int QUEUE_DEPTH  = 64;
   localparam int PACKET_BYTES = 8;
   localparam int IDX_W        = $clog2(PACKET_BYTES);
   localparam int CACHE_DEPTH  = 256;
   localparam int MSG_W        = 16;

   localparam logic [7:0] PAD_BYTE    = 8'd145;
   localparam logic [7:0] STATUS_NOTE = 8'd144;
   localparam logic [7:0] STATUS_CC   = 8'd176;
   localparam logic [6:0] TOP_BASE    = 7'd104;
   localparam logic [6:0] ROW_STRIDE  = 7'd16;
   localparam logic [6:0] SIDE_OFFSET = 7'd8;

   localparam logic REQ_BUTTON = 1'b0;
   localparam logic REQ_PACKET = 1'b1;

   localparam logic KIND_ACK  = 1'b0;
   localparam logic KIND_BYTE = 1'b1;

   localparam logic [1:0] GROUP_GRID = 2'd0;
   localparam logic [1:0] GROUP_TOP  = 2'd1;
   localparam logic [1:0] GROUP_SIDE = 2'd2;

   typedef enum logic [1:0] {
      SET_QUEUED,
      SET_UNCHANGED,
      SET_INVALID,
      SET_DROPPED
   } set_status_type;

   typedef struct packed {
      logic       is_packet;
      logic       invalid;
      logic       cc;
      logic [6:0] note;
      logic [7:0] vel;
   } cmd_type;

   typedef struct packed {
      logic             result_kind;
      logic [1:0]       set_status;
      logic [7:0]       packet_byte;
      logic [IDX_W-1:0] byte_index;
      logic             last;
   } rsp_type;

endpackage
`default_nettype wire

// ===== src/bpk_req_if.sv =====
// Request channel interface carrying button and packet requests.
`default_nettype none
interface bpk_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [1:0] button_group;
   logic [3:0] button_row;
   logic [3:0] button_col;
   logic [7:0] velocity;

   modport source (output valid, output req_type, output button_group, output button_row,
                   output button_col, output velocity, input ready);
   modport sink (input valid, input req_type, input button_group, input button_row,
                 input button_col, input velocity, output ready);
endinterface
`default_nettype wire

// ===== src/bpk_rsp_if.sv =====
// Response channel interface carrying acknowledgements and packet bytes.
`default_nettype none
interface bpk_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [1:0] set_status;
   logic [7:0] packet_byte;
   logic [2:0] byte_index;
   logic       last;

   modport source (output valid, output result_kind, output set_status, output packet_byte,
                   output byte_index, output last, input ready);
   modport sink (input valid, input result_kind, input set_status, input packet_byte,
                 input byte_index, input last, output ready);
endinterface
`default_nettype wire

// ===== src/button_led_midi_packet_packer.sv =====
// Top level of the button-light MIDI packet packer.
// The req_if channel takes one transaction per request: req_type 0 sets a button light
// (button_group, button_row, button_col, velocity), req_type 1 asks for one 8-byte packet.
// The rsp_if channel returns one acknowledgement transaction per button request, carrying
// set_status, or eight packet_byte transactions per packet request, byte_index 0 to 7,
// with last set on the final transaction of each request.
// A two-entry command queue sits between the request decoder and the execution engine,
// so requests are taken while an earlier one is still being worked on.
// A button request reads the velocity cache, then S_CHECK writes its acknowledgement into
// the output register once that register is free. For a packet request every message
// costs one message RAM read and one packing decision before its bytes are emitted.
// Requests are executed one at a time by the engine state machine.
// Reset empties the message queue and the command queue and marks every velocity cache
// entry as zero through per-entry valid flags, so no clearing pass is needed.
// When rsp_if stalls, the output register holds its transaction and the engine waits;
// the command queue keeps accepting until it is full, then req_if.ready falls.
`default_nettype none
module button_led_midi_packet_packer #(
   parameter int QUEUE_DEPTH = bpk_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   bpk_req_if.sink   req_if,
   bpk_rsp_if.source rsp_if
);

   logic             cmd_valid;
   logic             cmd_ready;
   bpk_pkg::cmd_type cmd;

   bpk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   bpk_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_if    (rsp_if)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.result_kind == bpk_pkg::KIND_ACK)
      |-> rsp_if.last && (rsp_if.byte_index == 3'd0) && (rsp_if.packet_byte == 8'd0))
      else $error("Acknowledgement transaction is not a single last result.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.result_kind == bpk_pkg::KIND_BYTE)
      |-> (rsp_if.last == (rsp_if.byte_index == 3'(bpk_pkg::PACKET_BYTES - 1))))
      else $error("Packet byte last flag does not match the final byte position.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.result_kind == bpk_pkg::KIND_BYTE)
      |-> (rsp_if.set_status == bpk_pkg::SET_QUEUED))
      else $error("Packet byte carries a nonzero status.");

   assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd_ready && cmd.is_packet |=> !cmd_ready)
      else $error("Engine took a new command right after starting a packet.");

endmodule
`default_nettype wire

// ===== src/bpk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bpk_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/bpk_front.sv =====
// Front end: accepts requests, maps buttons to MIDI notes and queues commands.
`default_nettype none
module bpk_front (
   input  logic             clock,
   input  logic             reset,
   bpk_req_if.sink          req_if,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output bpk_pkg::cmd_type cmd
);

   localparam int Depth = 2;

   bpk_pkg::cmd_type q_ff [Depth];
   bpk_pkg::cmd_type cls;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   always_comb begin
      cls.is_packet = (req_if.req_type == bpk_pkg::REQ_PACKET);
      cls.vel       = req_if.velocity;
      cls.cc        = 1'b0;
      cls.note      = 7'd0;
      cls.invalid   = 1'b0;
      case (req_if.button_group)
         bpk_pkg::GROUP_GRID: begin
            cls.invalid = req_if.button_row[3] | req_if.button_col[3];
            cls.note    = 7'(req_if.button_row[2:0]) * bpk_pkg::ROW_STRIDE
                          + 7'(req_if.button_col[2:0]);
         end
         bpk_pkg::GROUP_TOP: begin
            cls.invalid = req_if.button_col[3];
            cls.cc      = 1'b1;
            cls.note    = bpk_pkg::TOP_BASE + 7'(req_if.button_col[2:0]);
         end
         bpk_pkg::GROUP_SIDE: begin
            cls.invalid = req_if.button_row[3];
            cls.note    = 7'(req_if.button_row[2:0]) * bpk_pkg::ROW_STRIDE
                          + bpk_pkg::SIDE_OFFSET;
         end
         default: begin
            cls.invalid = 1'b1;
         end
      endcase
   end

   assign req_if.ready = (cnt_ff != 2'(Depth));
   assign cmd_valid    = (cnt_ff != 2'd0);
   assign cmd          = q_ff[rd_ptr_ff];
   assign push         = req_if.valid && req_if.ready;
   assign pop          = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

// ===== src/bpk_back.sv =====
// Back end: velocity cache, message queue, packet packing and the response register.
`default_nettype none
module bpk_back #(
   parameter int QUEUE_DEPTH = bpk_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  bpk_pkg::cmd_type cmd,
   bpk_rsp_if.source        rsp_if
);

   localparam int AddrW = $clog2(QUEUE_DEPTH);
   localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
   localparam int KeyW  = $clog2(bpk_pkg::CACHE_DEPTH);
   localparam int IdxW  = bpk_pkg::IDX_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_FETCH,
      S_LOAD,
      S_EMIT,
      S_PAD
   } state_type;

   state_type                       state_ff, state_in;
   bpk_pkg::cmd_type                cmd_ff, cmd_in;
   logic [AddrW-1:0]                head_ff, head_in;
   logic [AddrW-1:0]                tail_ff, tail_in;
   logic [CntW-1:0]                 count_ff, count_in;
   logic [IdxW-1:0]                 pos_ff, pos_in;
   logic                            prev_valid_ff, prev_valid_in;
   logic                            prev_cc_ff, prev_cc_in;
   logic [bpk_pkg::MSG_W-1:0]       msg_ff, msg_in;
   logic [1:0]                      step_ff, step_in;
   logic                            out_valid_ff, out_valid_in;
   bpk_pkg::rsp_type                out_ff, out_in;
   logic [bpk_pkg::CACHE_DEPTH-1:0] cache_valid_ff, cache_valid_in;

   logic                      msg_wr_en, msg_rd_en;
   logic [bpk_pkg::MSG_W-1:0] msg_rdata;
   logic                      cache_wr_en, cache_rd_en;
   logic [KeyW-1:0]           cache_rd_addr, key_ff;
   logic [7:0]                cache_rdata, cached;
   logic                      out_free, change, fits;
   logic [AddrW-1:0]          tail_next, head_next;
   logic [7:0]                status_byte;

   assign key_ff        = {cmd_ff.cc, cmd_ff.note};
   assign cache_rd_addr = {cmd.cc, cmd.note};
   assign cached        = cache_valid_ff[key_ff] ? cache_rdata : 8'd0;
   assign out_free      = !out_valid_ff || rsp_if.ready;
   assign tail_next     = (tail_ff == AddrW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + AddrW'(1);
   assign head_next     = (head_ff == AddrW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AddrW'(1);
   assign change        = !prev_valid_ff || (prev_cc_ff != msg_rdata[15]);
   assign fits          = change ? (pos_ff <= IdxW'(bpk_pkg::PACKET_BYTES - 3))
                                 : (pos_ff <= IdxW'(bpk_pkg::PACKET_BYTES - 2));
   assign status_byte   = msg_ff[15] ? bpk_pkg::STATUS_CC : bpk_pkg::STATUS_NOTE;
   assign cmd_ready     = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      pos_in         = pos_ff;
      prev_valid_in  = prev_valid_ff;
      prev_cc_in     = prev_cc_ff;
      msg_in         = msg_ff;
      step_in        = step_ff;
      cache_valid_in = cache_valid_ff;
      out_valid_in   = out_valid_ff && !rsp_if.ready;
      out_in         = out_ff;
      msg_wr_en      = 1'b0;
      msg_rd_en      = 1'b0;
      cache_wr_en    = 1'b0;
      cache_rd_en    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd;
               if (cmd.is_packet) begin
                  pos_in        = '0;
                  prev_valid_in = 1'b0;
                  state_in      = S_FETCH;
               end else begin
                  cache_rd_en = 1'b1;
                  state_in    = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (out_free) begin
               out_valid_in           = 1'b1;
               out_in.result_kind     = bpk_pkg::KIND_ACK;
               out_in.packet_byte     = 8'd0;
               out_in.byte_index      = '0;
               out_in.last            = 1'b1;
               if (cmd_ff.invalid) begin
                  out_in.set_status = bpk_pkg::SET_INVALID;
               end else if (cached == cmd_ff.vel) begin
                  out_in.set_status = bpk_pkg::SET_UNCHANGED;
               end else if (count_ff == CntW'(QUEUE_DEPTH)) begin
                  out_in.set_status = bpk_pkg::SET_DROPPED;
               end else begin
                  out_in.set_status      = bpk_pkg::SET_QUEUED;
                  msg_wr_en              = 1'b1;
                  cache_wr_en            = 1'b1;
                  cache_valid_in[key_ff] = 1'b1;
                  tail_in                = tail_next;
                  count_in               = count_ff + CntW'(1);
               end
               state_in = S_IDLE;
            end
         end
         S_FETCH: begin
            if (count_ff == '0) begin
               state_in = S_PAD;
            end else begin
               msg_rd_en = 1'b1;
               state_in  = S_LOAD;
            end
         end
         S_LOAD: begin
            if (fits) begin
               msg_in        = msg_rdata;
               step_in       = change ? 2'd0 : 2'd1;
               prev_valid_in = 1'b1;
               prev_cc_in    = msg_rdata[15];
               head_in       = head_next;
               count_in      = count_ff - CntW'(1);
               state_in      = S_EMIT;
            end else begin
               state_in = S_PAD;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.result_kind = bpk_pkg::KIND_BYTE;
               out_in.set_status  = bpk_pkg::SET_QUEUED;
               out_in.byte_index  = pos_ff;
               out_in.last        = (pos_ff == IdxW'(bpk_pkg::PACKET_BYTES - 1));
               case (step_ff)
                  2'd0:    out_in.packet_byte = status_byte;
                  2'd1:    out_in.packet_byte = {1'b0, msg_ff[14:8]};
                  default: out_in.packet_byte = msg_ff[7:0];
               endcase
               pos_in = pos_ff + IdxW'(1);
               if (step_ff == 2'd2) begin
                  state_in = (pos_ff == IdxW'(bpk_pkg::PACKET_BYTES - 1)) ? S_IDLE : S_FETCH;
               end else begin
                  step_in = step_ff + 2'd1;
               end
            end
         end
         S_PAD: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.result_kind = bpk_pkg::KIND_BYTE;
               out_in.set_status  = bpk_pkg::SET_QUEUED;
               out_in.packet_byte = bpk_pkg::PAD_BYTE;
               out_in.byte_index  = pos_ff;
               out_in.last        = (pos_ff == IdxW'(bpk_pkg::PACKET_BYTES - 1));
               pos_in             = pos_ff + IdxW'(1);
               if (pos_ff == IdxW'(bpk_pkg::PACKET_BYTES - 1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         pos_ff         <= '0;
         prev_valid_ff  <= 1'b0;
         prev_cc_ff     <= 1'b0;
         step_ff        <= 2'd0;
         out_valid_ff   <= 1'b0;
         cache_valid_ff <= '0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         pos_ff         <= pos_in;
         prev_valid_ff  <= prev_valid_in;
         prev_cc_ff     <= prev_cc_in;
         step_ff        <= step_in;
         out_valid_ff   <= out_valid_in;
         cache_valid_ff <= cache_valid_in;
      end
      cmd_ff <= cmd_in;
      msg_ff <= msg_in;
      out_ff <= out_in;
   end

   bpk_ram #(
      .WIDTH (bpk_pkg::MSG_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_msg_ram (
      .clock   (clock),
      .wr_en   (msg_wr_en),
      .wr_addr (tail_ff),
      .wr_data ({cmd_ff.cc, cmd_ff.note, cmd_ff.vel}),
      .rd_en   (msg_rd_en),
      .rd_addr (head_ff),
      .rd_data (msg_rdata)
   );

   bpk_ram #(
      .WIDTH (8),
      .DEPTH (bpk_pkg::CACHE_DEPTH)
   ) u_cache_ram (
      .clock   (clock),
      .wr_en   (cache_wr_en),
      .wr_addr (key_ff),
      .wr_data (cmd_ff.vel),
      .rd_en   (cache_rd_en),
      .rd_addr (cache_rd_addr),
      .rd_data (cache_rdata)
   );

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.result_kind = out_ff.result_kind;
   assign rsp_if.set_status  = out_ff.set_status;
   assign rsp_if.packet_byte = out_ff.packet_byte;
   assign rsp_if.byte_index  = out_ff.byte_index;
   assign rsp_if.last        = out_ff.last;

endmodule
`default_nettype wire
